[hw/rtl/clcb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package clcb_pkg;

    localparam logic [3:0] KIND_WRITE = 4'd0;
    localparam logic [3:0] KIND_LEFT  = 4'd1;
    localparam logic [3:0] KIND_RIGHT = 4'd2;
    localparam logic [3:0] KIND_UP    = 4'd3;
    localparam logic [3:0] KIND_DOWN  = 4'd4;
    localparam logic [3:0] KIND_CLEAR = 4'd5;
    localparam logic [3:0] KIND_EOL   = 4'd6;
    localparam logic [3:0] KIND_SET   = 4'd7;
    localparam logic [3:0] KIND_READ  = 4'd8;

    localparam logic [7:0] SPACE_CODE = 8'd32;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_BLANK  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/char_lcd_cursor_buffer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// A word is accepted in the idle state. Moves, sets, writes and clears go straight to
// the finish state, a cell read passes through the read state, and a clear to end of line
// through the blank state, which writes one space per cycle through the cell RAM port.
// No new word is taken before the last result is loaded out. Reset homes the cursor and
// clears the per-cell valid flags, so every cell reads as zero without a clearing pass.
module char_lcd_cursor_buffer_unit #(
    parameter int COLUMNS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [3:0] kind,
    input  wire logic [7:0] char_code,
    input  wire logic [1:0] target_row,
    input  wire logic [4:0] target_column,
    input  wire logic [4:0] read_index,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            ok,
    output logic            cursor_row,
    output logic [3:0]      cursor_column,
    output logic [7:0]      cell_data
);

    import clcb_pkg::*;

    localparam int CELLS = 2 * COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = $clog2(CELLS);

    state_t          state_reg, state_next;
    logic            row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [CW-1:0]   blank_col_reg, blank_col_next;
    logic [CELLS-1:0] valid_reg, valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            res_ok_reg, res_ok_next;
    logic [7:0]      res_data_reg, res_data_next;
    logic            rd_valid_reg, rd_valid_next;
    logic            out_ok_reg, out_row_reg;
    logic [CW-1:0]   out_col_reg;
    logic [7:0]      out_data_reg;

    logic            accept;
    logic            load_out;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic [AW-1:0]   cur_idx;
    logic [AW-1:0]   blank_idx;
    logic            at_last_col;
    logic            right_ok;
    logic            set_ok;
    logic            read_ok;

    clcb_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    assign cur_idx     = row_reg ? (AW'(COLUMNS) + AW'(col_reg)) : AW'(col_reg);
    assign blank_idx   = row_reg ? (AW'(COLUMNS) + AW'(blank_col_reg)) : AW'(blank_col_reg);
    assign at_last_col = (col_reg == CW'(COLUMNS - 1));
    assign right_ok    = !at_last_col || !row_reg;
    assign set_ok      = (target_row < 2'd2) && ({2'b00, target_column} < 7'(COLUMNS));
    assign read_ok     = ({3'b000, read_index} < 8'(CELLS));

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        blank_col_next = blank_col_reg;
        valid_next     = valid_reg;
        res_ok_next    = res_ok_reg;
        res_data_next  = res_data_reg;
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_idx;
        ram_wdata      = char_code;
        ram_re         = 1'b0;
        ram_raddr      = AW'(read_index);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_ok_next   = 1'b1;
                    res_data_next = 8'd0;
                    state_next    = ST_FINISH;
                    case (kind)
                        KIND_WRITE:
                        begin
                            ram_we              = 1'b1;
                            valid_next[cur_idx] = 1'b1;
                            if (!at_last_col)
                            begin
                                col_next = col_reg + 1'b1;
                            end
                            else if (!row_reg)
                            begin
                                row_next = 1'b1;
                                col_next = '0;
                            end
                        end
                        KIND_LEFT:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - 1'b1;
                            end
                            else if (row_reg)
                            begin
                                row_next = 1'b0;
                                col_next = CW'(COLUMNS - 1);
                            end
                            else
                            begin
                                res_ok_next = 1'b0;
                            end
                        end
                        KIND_RIGHT:
                        begin
                            res_ok_next = right_ok;
                            if (!at_last_col)
                            begin
                                col_next = col_reg + 1'b1;
                            end
                            else if (!row_reg)
                            begin
                                row_next = 1'b1;
                                col_next = '0;
                            end
                        end
                        KIND_UP:
                        begin
                            res_ok_next = row_reg;
                            row_next    = 1'b0;
                        end
                        KIND_DOWN:
                        begin
                            res_ok_next = !row_reg;
                            row_next    = 1'b1;
                        end
                        KIND_CLEAR:
                        begin
                            valid_next = '0;
                            row_next   = 1'b0;
                            col_next   = '0;
                        end
                        KIND_EOL:
                        begin
                            blank_col_next = col_reg;
                            state_next     = ST_BLANK;
                        end
                        KIND_SET:
                        begin
                            res_ok_next = set_ok;
                            if (set_ok)
                            begin
                                row_next = target_row[0];
                                col_next = CW'(target_column);
                            end
                        end
                        KIND_READ:
                        begin
                            res_ok_next = read_ok;
                            if (read_ok)
                            begin
                                ram_re        = 1'b1;
                                rd_valid_next = valid_reg[AW'(read_index)];
                                state_next    = ST_READ;
                            end
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_data_next = rd_valid_reg ? ram_rdata : 8'd0;
                state_next    = ST_FINISH;
            end
            ST_BLANK:
            begin
                ram_we                = 1'b1;
                ram_waddr             = blank_idx;
                ram_wdata             = SPACE_CODE;
                valid_next[blank_idx] = 1'b1;
                blank_col_next        = blank_col_reg + 1'b1;
                if (blank_col_reg == CW'(COLUMNS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= 1'b0;
            col_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blank_col_reg <= blank_col_next;
        res_ok_reg    <= res_ok_next;
        res_data_reg  <= res_data_next;
        rd_valid_reg  <= rd_valid_next;
        if (load_out)
        begin
            out_ok_reg   <= res_ok_reg;
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            out_data_reg <= res_data_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = out_ok_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_column = 4'(out_col_reg);
    assign cell_data     = out_data_reg;

endmodule

`default_nettype wire

[hw/rtl/clcb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module clcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
